>>> rtl/core/polygon_pair_intersection_test_top_macros.svh
// Assertion macros for the polygon pair intersection test checker.
// Depends on nothing; the including scope must provide aclk and aresetn.
`ifndef POLYGON_PAIR_INTERSECTION_TEST_TOP_MACROS_SVH
`define POLYGON_PAIR_INTERSECTION_TEST_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ppit_pkg.sv
// Shared types and constants for the polygon pair intersection test.
// No dependencies.
package ppit_pkg;

    localparam int PPIT_MAX_VERTICES = 64;
    localparam int PPIT_COORD_BITS   = 16;

    // Sign of a cross product: negative, zero, positive when both clear.
    typedef struct packed {
        logic neg;
        logic zero;
    } ppit_sgn_t;

    // Status from the test engine back to the top level.
    typedef struct packed {
        logic done;
        logic meet;
    } ppit_res_t;

endpackage

>>> rtl/core/ppit_vstore.sv
// Vertex store: single write port, single read port, registered read data.
// Depends on nothing.
module ppit_vstore #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/ppit_orient.sv
// Three-stage orientation pipeline: sign of (q - p) x (r - p).
// Depends on ppit_pkg.
module ppit_orient #(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [2*COORD_BITS-1:0]   p,
    input  logic [2*COORD_BITS-1:0]   q,
    input  logic [2*COORD_BITS-1:0]   r,
    output logic                      out_valid,
    output ppit_pkg::ppit_sgn_t       out_sign
);
    import ppit_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int SW = 2 * CB + 3;

    logic signed [CB-1:0] px, py, qx, qy, rx, ry;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic signed [SW-1:0] diff;
    logic                 v1_reg, v2_reg, v3_reg;
    ppit_sgn_t            sign_reg;

    assign px = $signed(p[CB-1:0]);
    assign py = $signed(p[2*CB-1:CB]);
    assign qx = $signed(q[CB-1:0]);
    assign qy = $signed(q[2*CB-1:CB]);
    assign rx = $signed(r[CB-1:0]);
    assign ry = $signed(r[2*CB-1:CB]);
    assign diff = SW'(m1_reg) - SW'(m2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        dx1_reg       <= DW'(qx) - DW'(px);
        dy1_reg       <= DW'(qy) - DW'(py);
        dx2_reg       <= DW'(rx) - DW'(px);
        dy2_reg       <= DW'(ry) - DW'(py);
        m1_reg        <= PW'(dx1_reg) * PW'(dy2_reg);
        m2_reg        <= PW'(dy1_reg) * PW'(dx2_reg);
        sign_reg.neg  <= diff[SW-1];
        sign_reg.zero <= (diff == '0);
    end

    assign out_valid = v3_reg;
    assign out_sign  = sign_reg;
endmodule

>>> rtl/core/ppit_engine.sv
// Test sequencer: walks edge pairs, then the two containment passes, reading
// both vertex stores and feeding the shared orientation pipeline.
// Depends on ppit_pkg and ppit_orient.
module ppit_engine #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] count_a,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] count_b,
    output logic [$clog2(MAX_VERTICES)-1:0]   raddr_a,
    output logic [$clog2(MAX_VERTICES)-1:0]   raddr_b,
    input  logic [2*COORD_BITS-1:0]           rdata_a,
    input  logic [2*COORD_BITS-1:0]           rdata_b,
    output ppit_pkg::ppit_res_t               res
);
    import ppit_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int VW = 2 * CB;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = AW + 1;

    typedef enum logic [4:0] {
        E_IDLE, E_RA1, E_RA2, E_RA3, E_RB1, E_RB2, E_RBW, E_ISS, E_WAIT, E_EVAL,
        E_CP, E_CP2, E_CR1, E_CR2, E_CR3, E_CISS, E_CWAIT, E_CEVAL, E_DONE
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   i_reg, j_reg, e_reg;
    logic [1:0]      k_reg, rk_reg;
    logic            pass_reg, inside_reg, meet_reg;
    logic [VW-1:0]   v_reg [4];
    ppit_sgn_t       o_reg [4];

    logic            o_in_valid, o_valid;
    logic [VW-1:0]   op, oq, orr, pt_data, poly_data;
    ppit_sgn_t       o_sign;
    logic [CW-1:0]   n_poly;
    logic            i_last, j_last, e_last;
    logic [AW-1:0]   i_next, j_next, e_prev;
    logic            meet_edge, on_edge, toggle, inside_next;
    logic signed [CB-1:0] py0, py1, py2;

    function automatic logic idx_last(input logic [AW-1:0] idx, input logic [CW-1:0] n);
        return (XW'(idx) + XW'(1)) == XW'(n);
    endfunction

    function automatic logic on_seg(input logic [VW-1:0] p, input logic [VW-1:0] a,
                                    input logic [VW-1:0] b, input ppit_sgn_t o);
        logic signed [CB-1:0] px, py, ax, ay, bx, by;
        logic                 x_ok, y_ok;
        px = $signed(p[CB-1:0]);
        py = $signed(p[VW-1:CB]);
        ax = $signed(a[CB-1:0]);
        ay = $signed(a[VW-1:CB]);
        bx = $signed(b[CB-1:0]);
        by = $signed(b[VW-1:CB]);
        x_ok = (px >= ax && px <= bx) || (px <= ax && px >= bx);
        y_ok = (py >= ay && py <= by) || (py <= ay && py >= by);
        if (a == b) begin
            return p == a;
        end
        // collinear and inside the bounding box means on the segment
        return o.zero && x_ok && y_ok;
    endfunction

    assign i_last = idx_last(i_reg, count_a);
    assign j_last = idx_last(j_reg, count_b);
    assign n_poly = pass_reg ? count_a : count_b;
    assign e_last = idx_last(e_reg, n_poly);
    assign i_next = i_last ? '0 : i_reg + AW'(1);
    assign j_next = j_last ? '0 : j_reg + AW'(1);
    assign e_prev = (e_reg == '0) ? AW'(n_poly - CW'(1)) : e_reg - AW'(1);

    // pass 0 tests A's first vertex against B, pass 1 the other way round
    assign pt_data   = pass_reg ? rdata_b : rdata_a;
    assign poly_data = pass_reg ? rdata_a : rdata_b;

    always_comb begin
        raddr_a = '0;
        raddr_b = '0;
        unique case (state_reg)
            E_RA1:   raddr_a = i_reg;
            E_RA2:   raddr_a = i_next;
            E_RB1:   raddr_b = j_reg;
            E_RB2:   raddr_b = j_next;
            E_CR1: begin
                raddr_a = e_reg;
                raddr_b = e_reg;
            end
            E_CR2: begin
                raddr_a = e_prev;
                raddr_b = e_prev;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_valid = 1'b0;
        op  = v_reg[1];
        oq  = v_reg[2];
        orr = v_reg[0];
        if (state_reg == E_ISS) begin
            o_in_valid = 1'b1;
            unique case (k_reg)
                2'd0: begin op = v_reg[0]; oq = v_reg[1]; orr = v_reg[2]; end
                2'd1: begin op = v_reg[0]; oq = v_reg[1]; orr = v_reg[3]; end
                2'd2: begin op = v_reg[2]; oq = v_reg[3]; orr = v_reg[0]; end
                default: begin op = v_reg[2]; oq = v_reg[3]; orr = v_reg[1]; end
            endcase
        end else if (state_reg == E_CISS) begin
            o_in_valid = 1'b1;
        end
    end

    ppit_orient #(.COORD_BITS(COORD_BITS)) u_orient (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (o_in_valid),
        .p         (op),
        .q         (oq),
        .r         (orr),
        .out_valid (o_valid),
        .out_sign  (o_sign)
    );

    // edge pair: a1 = v0, a2 = v1, b1 = v2, b2 = v3
    assign meet_edge = on_seg(v_reg[0], v_reg[2], v_reg[3], o_reg[2]) ||
                       on_seg(v_reg[1], v_reg[2], v_reg[3], o_reg[3]) ||
                       on_seg(v_reg[2], v_reg[0], v_reg[1], o_reg[0]) ||
                       on_seg(v_reg[3], v_reg[0], v_reg[1], o_reg[1]) ||
                       ((o_reg[0] != o_reg[1]) && (o_reg[2] != o_reg[3]));

    // containment: point = v0, previous vertex = v1, current vertex = v2
    assign py0 = $signed(v_reg[0][VW-1:CB]);
    assign py1 = $signed(v_reg[1][VW-1:CB]);
    assign py2 = $signed(v_reg[2][VW-1:CB]);
    assign on_edge = on_seg(v_reg[0], v_reg[1], v_reg[2], o_reg[0]);
    assign toggle  = ((py2 > py0) != (py1 > py0)) &&
                     ((py1 > py2) ? o_reg[0].neg : (!o_reg[0].neg && !o_reg[0].zero));
    assign inside_next = inside_reg ^ toggle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            meet_reg  <= 1'b0;
            rk_reg    <= '0;
        end else begin
            if (o_valid) begin
                o_reg[rk_reg] <= o_sign;
                rk_reg        <= rk_reg + 2'd1;
            end
            unique case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        pass_reg  <= 1'b0;
                        state_reg <= E_RA1;
                    end
                end
                E_RA1: state_reg <= E_RA2;
                E_RA2: begin
                    v_reg[0]  <= rdata_a;
                    state_reg <= E_RA3;
                end
                E_RA3: begin
                    v_reg[1]  <= rdata_a;
                    state_reg <= E_RB1;
                end
                E_RB1: state_reg <= E_RB2;
                E_RB2: begin
                    v_reg[2]  <= rdata_b;
                    state_reg <= E_RBW;
                end
                E_RBW: begin
                    v_reg[3]  <= rdata_b;
                    k_reg     <= '0;
                    rk_reg    <= '0;
                    state_reg <= E_ISS;
                end
                E_ISS: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= E_WAIT;
                    end
                end
                E_WAIT: begin
                    if (o_valid && rk_reg == 2'd3) begin
                        state_reg <= E_EVAL;
                    end
                end
                E_EVAL: begin
                    if (meet_edge) begin
                        meet_reg  <= 1'b1;
                        state_reg <= E_DONE;
                    end else if (j_last) begin
                        j_reg <= '0;
                        if (i_last) begin
                            pass_reg  <= 1'b0;
                            state_reg <= E_CP;
                        end else begin
                            i_reg     <= i_next;
                            state_reg <= E_RA1;
                        end
                    end else begin
                        j_reg     <= j_next;
                        state_reg <= E_RB1;
                    end
                end
                E_CP: state_reg <= E_CP2;
                E_CP2: begin
                    v_reg[0]   <= pt_data;
                    e_reg      <= '0;
                    inside_reg <= 1'b0;
                    state_reg  <= E_CR1;
                end
                E_CR1: state_reg <= E_CR2;
                E_CR2: begin
                    v_reg[2]  <= poly_data;
                    state_reg <= E_CR3;
                end
                E_CR3: begin
                    v_reg[1]  <= poly_data;
                    rk_reg    <= '0;
                    state_reg <= E_CISS;
                end
                E_CISS: state_reg <= E_CWAIT;
                E_CWAIT: begin
                    if (o_valid) begin
                        state_reg <= E_CEVAL;
                    end
                end
                E_CEVAL: begin
                    if (on_edge) begin
                        meet_reg  <= 1'b1;
                        state_reg <= E_DONE;
                    end else if (e_last) begin
                        if (inside_next) begin
                            meet_reg  <= 1'b1;
                            state_reg <= E_DONE;
                        end else if (!pass_reg) begin
                            pass_reg  <= 1'b1;
                            state_reg <= E_CP;
                        end else begin
                            meet_reg  <= 1'b0;
                            state_reg <= E_DONE;
                        end
                    end else begin
                        inside_reg <= inside_next;
                        e_reg      <= e_reg + AW'(1);
                        state_reg  <= E_CR1;
                    end
                end
                E_DONE: state_reg <= E_IDLE;
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign res.done = (state_reg == E_DONE);
    assign res.meet = meet_reg;
endmodule

>>> rtl/core/polygon_pair_intersection_test_top.sv
// Polygon pair intersection test, top level: input loading, vertex stores,
// test engine and result register. Depends on ppit_pkg, ppit_vstore, ppit_engine.
//
// Vertices of polygon A (tuser = 0) and polygon B (tuser = 1) arrive one word
// per cycle while s_tready is high and are written straight into two vertex
// stores; extra vertices beyond MAX_VERTICES are dropped and reported in the
// overflow flag. The word on B with tlast set starts the test and yields one
// result word; tlast on A has no effect. During the test s_tready is low. Each
// edge pair of A x B reads four vertices and issues four orientations; each
// containment pass issues one orientation per edge of the tested polygon. The
// test time is set by the shared three-stage orientation pipeline and the single
// read port of each vertex store. An early hit ends the test at once. A result
// waits in the output register while the next pair loads.
module polygon_pair_intersection_test_top #(
    parameter int MAX_VERTICES = ppit_pkg::PPIT_MAX_VERTICES,
    parameter int COORD_BITS   = ppit_pkg::PPIT_COORD_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vertex_x, vertex_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // polygon_b
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // intersects, empty_input, overflow
    output logic [7:0]                            m_tdata
);
    import ppit_pkg::*;

    localparam int VW = 2 * COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {S_LOAD, S_START, S_TEST, S_EMIT} state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic          ovf_reg, meet_reg, empty_reg;
    logic          m_valid_reg, m_meet_reg, m_empty_reg, m_ovf_reg;

    logic          accept, full_a, full_b, we_a, we_b, is_empty, start;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [VW-1:0] rdata_a, rdata_b, vtx;
    ppit_res_t     res;

    assign s_tready = (state_reg == S_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign full_a   = (cnt_a_reg == CW'(MAX_VERTICES));
    assign full_b   = (cnt_b_reg == CW'(MAX_VERTICES));
    assign we_a     = accept && !s_tuser && !full_a;
    assign we_b     = accept && s_tuser && !full_b;
    assign vtx      = s_tdata[VW-1:0];
    assign is_empty = (cnt_a_reg == '0) || (cnt_b_reg == '0);
    assign start    = (state_reg == S_START) && !is_empty;

    ppit_vstore #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (vtx),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    ppit_vstore #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (vtx),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    ppit_engine #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .count_a (cnt_a_reg),
        .count_b (cnt_b_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_EMIT the output register is handled below
            if (m_valid_reg && m_tready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (accept) begin
                        if (we_a) begin
                            cnt_a_reg <= cnt_a_reg + CW'(1);
                        end
                        if (we_b) begin
                            cnt_b_reg <= cnt_b_reg + CW'(1);
                        end
                        // a dropped word still counts as overflow; tlast on B still starts
                        if ((!s_tuser && full_a) || (s_tuser && full_b)) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tuser && s_tlast) begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START: begin
                    if (is_empty) begin
                        meet_reg  <= 1'b0;
                        empty_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (res.done) begin
                        meet_reg  <= res.meet;
                        empty_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_meet_reg  <= meet_reg;
                        m_empty_reg <= empty_reg;
                        m_ovf_reg   <= ovf_reg;
                        cnt_a_reg   <= '0;
                        cnt_b_reg   <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_ovf_reg, m_empty_reg, m_meet_reg};
endmodule

>>> rtl/core/ppit_checker.sv
// Port-level checker for the polygon pair intersection test, bound to the top.
// Depends on polygon_pair_intersection_test_top_macros.svh.
module ppit_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
`include "polygon_pair_intersection_test_top_macros.svh"

    // hold a stalled result word
    `PPIT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    // an empty pair never reports a hit
    `PPIT_ASSERT_NOW(a_empty_no_hit, m_tvalid, !(m_tdata[0] && m_tdata[1]), "intersects set with empty_input")
    // the closing word of B stops input until the result is lodged
    `PPIT_ASSERT_NEXT(a_test_stalls_input, s_tvalid && s_tready && s_tuser && s_tlast, !s_tready, "input taken right after the closing word of B")
    // pad bits stay clear
    `PPIT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'b0, "result pad bits not zero")
endmodule

bind polygon_pair_intersection_test_top ppit_checker u_ppit_checker (.*);

>>> tb/sv/polygon_pair_intersection_test_top_tb.sv
// Testbench for polygon_pair_intersection_test_top: directed vertex table, then random
// polygon pairs under changing idle/stall phases, checked against an exact integer predictor.
// Depends on ppit_pkg and the RTL of the block.
`timescale 1ns / 1ps

module polygon_pair_intersection_test_top_tb;
    import ppit_pkg::*;

    localparam int NV        = PPIT_MAX_VERTICES;
    localparam int CB        = PPIT_COORD_BITS;
    localparam int N_RANDOM  = 1850;
    localparam longint LIMIT = 3000000;

    typedef struct {
        bit               poly_b;
        logic signed [CB-1:0] vx;
        logic signed [CB-1:0] vy;
        bit               last;
        bit               fixed;     // expected result typed into the row
        logic [2:0]       fixed_res; // {overflow, empty_input, intersects}
    } vertex_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // vertex_x, vertex_y
    logic        s_tuser;   // polygon_b
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // intersects, empty_input, overflow

    polygon_pair_intersection_test_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #10;
        aclk = 1'b1; #10;
    end

    // Predictor state: both vertex stores and their counts.
    longint     poly_ax[NV], poly_ay[NV], poly_bx[NV], poly_by[NV];
    int         cnt_a, cnt_b;
    bit         dropped;
    logic [2:0] verdict_q[$];

    int     idle_pct, stall_pct;
    int     n_errors, n_words, n_verdicts, n_meet, n_pairs;
    longint n_cycles;
    vertex_word_t directed_rows[$];

    function automatic int sgn(longint v);
        return (v < 0) ? -1 : (v != 0);
    endfunction

    function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
        return sgn((bx - ax) * (cy - ay) - (by - ay) * (cx - ax));
    endfunction

    function automatic bit on_seg(longint px, longint py, longint ax, longint ay,
                                  longint bx, longint by);
        longint dot, len;
        if (ax == bx && ay == by) begin
            return px == ax && py == ay;
        end
        if (orient(ax, ay, bx, by, px, py) != 0) begin
            return 0;
        end
        dot = (px - ax) * (bx - ax) + (py - ay) * (by - ay);
        len = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
        return dot >= 0 && len >= dot;
    endfunction

    function automatic bit edges_cross(longint a1x, longint a1y, longint a2x, longint a2y,
                                       longint b1x, longint b1y, longint b2x, longint b2y);
        if (on_seg(a1x, a1y, b1x, b1y, b2x, b2y) || on_seg(a2x, a2y, b1x, b1y, b2x, b2y) ||
            on_seg(b1x, b1y, a1x, a1y, a2x, a2y) || on_seg(b2x, b2y, a1x, a1y, a2x, a2y)) begin
            return 1;
        end
        return orient(a1x, a1y, a2x, a2y, b1x, b1y) != orient(a1x, a1y, a2x, a2y, b2x, b2y)
            && orient(b1x, b1y, b2x, b2y, a1x, a1y) != orient(b1x, b1y, b2x, b2y, a2x, a2y);
    endfunction

    // Ray casting; a point on the boundary counts as inside.
    function automatic bit point_inside(longint px, longint py, longint qx[NV],
                                        longint qy[NV], int n);
        bit in_poly;
        int j;
        longint dy;
        int d;
        in_poly = 0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            if (on_seg(px, py, qx[j], qy[j], qx[i], qy[i])) begin
                return 1;
            end
            if ((qy[i] > py) != (qy[j] > py)) begin
                dy = qy[j] - qy[i];
                d = sgn((px - qx[i]) * dy - (qx[j] - qx[i]) * (py - qy[i]));
                if (dy > 0 ? d < 0 : d > 0) begin
                    in_poly = !in_poly;
                end
            end
            j = i;
        end
        return in_poly;
    endfunction

    function automatic bit polygons_touch();
        int i2, j2;
        for (int i = 0; i < cnt_a; i++) begin
            i2 = (i + 1 == cnt_a) ? 0 : i + 1;
            for (int j = 0; j < cnt_b; j++) begin
                j2 = (j + 1 == cnt_b) ? 0 : j + 1;
                if (edges_cross(poly_ax[i], poly_ay[i], poly_ax[i2], poly_ay[i2],
                                poly_bx[j], poly_by[j], poly_bx[j2], poly_by[j2])) begin
                    return 1;
                end
            end
        end
        if (point_inside(poly_ax[0], poly_ay[0], poly_bx, poly_by, cnt_b)) begin
            return 1;
        end
        return point_inside(poly_bx[0], poly_by[0], poly_ax, poly_ay, cnt_a);
    endfunction

    // Advance the predictor by one accepted word; queue a verdict when B closes.
    task automatic predict_word(vertex_word_t w);
        logic [2:0] res;
        if (!w.poly_b) begin
            if (cnt_a < NV) begin
                poly_ax[cnt_a] = w.vx;
                poly_ay[cnt_a] = w.vy;
                cnt_a++;
            end else begin
                dropped = 1;
            end
            return;
        end
        if (cnt_b < NV) begin
            poly_bx[cnt_b] = w.vx;
            poly_by[cnt_b] = w.vy;
            cnt_b++;
        end else begin
            dropped = 1;
        end
        if (!w.last) begin
            return;
        end
        if (cnt_a == 0 || cnt_b == 0) begin
            res = {dropped, 2'b10};
        end else begin
            res = {dropped, 1'b0, polygons_touch()};
        end
        verdict_q.push_back(w.fixed ? w.fixed_res : res);
        cnt_a = 0;
        cnt_b = 0;
        dropped = 0;
        n_pairs++;
    endtask

    task automatic send_word(vertex_word_t w);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.vy, w.vx};
        s_tuser  <= w.poly_b;
        s_tlast  <= w.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(w);
        n_words++;
    endtask

    function automatic vertex_word_t mk(bit b, int x, int y, bit last);
        vertex_word_t w;
        w.poly_b = b;
        w.vx = x;
        w.vy = y;
        w.last = last;
        w.fixed = 0;
        w.fixed_res = '0;
        return w;
    endfunction

    task automatic add_row(bit b, int x, int y, bit last);
        directed_rows.push_back(mk(b, x, y, last));
    endtask

    task automatic add_checked_row(bit b, int x, int y, logic [2:0] res);
        vertex_word_t w;
        w = mk(b, x, y, 1);
        w.fixed = 1;
        w.fixed_res = res;
        directed_rows.push_back(w);
    endtask

    function automatic int rand_coord(int center, int span);
        int v;
        v = center + $urandom_range(2 * span) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // One random pair: well-formed mostly, with stray A last flags, A words after B
    // words, empty A, and now and then a store overrun.
    task automatic send_pair();
        int na, nb, ca, cb, span, pick, a_late;
        pick = $urandom_range(99);
        na = (pick < 3) ? $urandom_range(70, 60) : (pick < 8) ? 0 : $urandom_range(8, 1);
        pick = $urandom_range(99);
        nb = (pick < 3) ? $urandom_range(70, 60) : $urandom_range(8, 1);
        pick = $urandom_range(9);
        span = (pick < 4) ? 20 : (pick < 8) ? 2000 : 32767;
        ca = (span == 32767) ? 0 : rand_coord(0, 30000);
        cb = ($urandom_range(3) == 0) ? rand_coord(0, 30000) : rand_coord(ca, span);
        a_late = ($urandom_range(9) == 0) ? $urandom_range(na) : 0;
        for (int i = 0; i < na - a_late; i++) begin
            send_word(mk(0, rand_coord(ca, span), rand_coord(ca, span), $urandom_range(1)));
        end
        for (int i = 0; i < nb; i++) begin
            if (i == nb - 1) begin
                for (int k = 0; k < a_late; k++) begin
                    send_word(mk(0, rand_coord(ca, span), rand_coord(ca, span), 0));
                end
            end
            send_word(mk(1, rand_coord(cb, span), rand_coord(cb, span), i == nb - 1));
        end
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on result word %0d: %s got %0d, want %0d",
                 n_verdicts, field, got, want);
        n_errors++;
    endtask

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                logic [2:0] want;
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want[0]) report_mismatch("intersects", m_tdata[0], want[0]);
                if (m_tdata[1] !== want[1]) report_mismatch("empty_input", m_tdata[1], want[1]);
                if (m_tdata[2] !== want[2]) report_mismatch("overflow", m_tdata[2], want[2]);
                n_meet += want[0];
            end
            n_verdicts++;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        n_errors = 0; n_words = 0; n_verdicts = 0; n_meet = 0; n_pairs = 0;
        n_cycles = 0;
        cnt_a = 0; cnt_b = 0; dropped = 0;

        // empty A
        add_checked_row(1, 0, 0, 3'b010);
        // full-range square around the origin, A last flag in the middle
        add_row(0, -32768, -32768, 0);
        add_row(0, 32767, -32768, 0);
        add_row(0, 32767, 32767, 1);
        add_row(0, -32768, 32767, 0);
        add_row(1, 0, 0, 1);
        // single points: equal, then apart
        add_row(0, 5, 5, 0);
        add_checked_row(1, 5, 5, 3'b001);
        add_row(0, 1, 1, 0);
        add_checked_row(1, 2, 2, 3'b000);
        // A words arriving between B words
        add_row(1, 0, 0, 0);
        add_row(1, 10, 0, 0);
        add_row(0, 5, -5, 0);
        add_row(0, 5, 5, 0);
        add_row(1, 10, 10, 1);
        // corner touch
        add_row(0, 0, 0, 0);
        add_row(0, 4, 0, 0);
        add_row(0, 4, 4, 0);
        add_row(0, 0, 4, 0);
        add_row(1, 4, 4, 0);
        add_row(1, 8, 4, 0);
        add_row(1, 8, 8, 1);
        // repeated vertex inside a large triangle
        add_row(0, 3, 3, 0);
        add_row(0, 3, 3, 0);
        add_row(0, 9, 3, 0);
        add_row(1, 0, 0, 0);
        add_row(1, 20, 0, 0);
        add_row(1, 0, 20, 1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) send_word(directed_rows[i]);

        // hold until the block has drained
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 14) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 14) : 0;
            while (n_words < 28 + (ph + 1) * N_RANDOM / 4) begin
                send_pair();
            end
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d vertex words in %0d polygon pairs, %0d result words (%0d meeting)",
                 n_words, n_pairs, n_verdicts, n_meet);
        $display("with empty polygons, store overruns and every idle/stall phase");
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
